// ===== rtl/sensor_frame_deframer_core_macros.svh =====
// assertion macros for the sensor frame deframer
// used by the top level only; no other dependencies
`ifndef SENSOR_FRAME_DEFRAMER_CORE_MACROS_SVH
`define SENSOR_FRAME_DEFRAMER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define SFD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfd assertion failed");

// next-cycle implication, disabled during reset
`define SFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfd assertion failed");

`endif

// ===== rtl/sfd_pkg.sv =====
// shared constants and types for the sensor frame deframer
// no dependencies
package sfd_pkg;

   localparam int WordCount = 5;
   localparam int BodyLen   = 25;
   localparam int RecordLen = 5;

   localparam int ByteWidth     = 8;
   localparam int WordWidth     = 32;
   localparam int CsrIndexWidth = 2;

   localparam logic [ByteWidth-1:0] HeaderResetValue = 8'hFF;
   localparam logic [ByteWidth-1:0] StartResetValue  = 8'h02;

   // configuration register indexes
   localparam logic [CsrIndexWidth-1:0] CsrHeaderIdx = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CsrStartIdx  = 2'd1;

   typedef logic [WordCount-1:0][WordWidth-1:0] sfd_words_type;

   // completed frame handed to the result register
   typedef struct packed {
      logic          emit;
      sfd_words_type words;
   } sfd_frame_type;

   // parser status seen by the top level
   typedef struct packed {
      logic hunting;
      logic checking;
   } sfd_status_type;

endpackage

// ===== rtl/sfd_channels.sv =====
// valid/ready channel interfaces of the sensor frame deframer
// depends on sfd_pkg
interface sfd_req_if import sfd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [ByteWidth-1:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfd_rsp_if import sfd_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [WordWidth-1:0] word_zero;
   logic [WordWidth-1:0] word_one;
   logic [WordWidth-1:0] word_two;
   logic [WordWidth-1:0] word_three;
   logic [WordWidth-1:0] word_four;

   modport source (output valid, output word_zero, output word_one, output word_two,
                   output word_three, output word_four, input ready);
   modport sink   (input valid, input word_zero, input word_one, input word_two,
                   input word_three, input word_four, output ready);
endinterface

// ===== rtl/sfd_parser.sv =====
// frame parser: header hunt, start check, record staging and checksum
// depends on sfd_pkg
module sfd_parser import sfd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [ByteWidth-1:0] rx_byte,
   input  logic [ByteWidth-1:0] header_byte,
   input  logic [ByteWidth-1:0] start_byte,
   output sfd_frame_type        frame,
   output sfd_status_type       status
);

   typedef enum logic [1:0] {
      PHASE_HUNT,
      PHASE_START,
      PHASE_BODY,
      PHASE_CHECK
   } phase_type;

   localparam int PosWidth  = $clog2(BodyLen);
   localparam int SlotWidth = $clog2(RecordLen);
   localparam int IdxWidth  = $clog2(WordCount);

   phase_type              phase_ff, phase_in;
   logic [PosWidth-1:0]    pos_ff, pos_in;
   logic [SlotWidth-1:0]   slot_ff, slot_in;
   logic [ByteWidth-1:0]   sum_ff, sum_in;
   logic [ByteWidth-1:0]   id_ff, id_in;
   sfd_words_type          stage_ff, stage_in;
   logic                   emit;
   logic [IdxWidth-1:0]    word_idx;
   logic                   id_ok;

   assign word_idx = id_ff[IdxWidth-1:0];
   assign id_ok    = (id_ff < ByteWidth'(WordCount));

   // next state for one accepted byte
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      slot_in  = slot_ff;
      sum_in   = sum_ff;
      id_in    = id_ff;
      stage_in = stage_ff;
      emit     = 1'b0;
      if (accept) begin
         unique case (phase_ff)
            PHASE_HUNT: begin
               if (rx_byte == header_byte) begin
                  sum_in   = rx_byte;
                  phase_in = PHASE_START;
               end
            end
            PHASE_START: begin
               if (rx_byte == start_byte) begin
                  sum_in   = sum_ff + rx_byte;
                  pos_in   = '0;
                  slot_in  = '0;
                  phase_in = PHASE_BODY;
               end else begin
                  phase_in = PHASE_HUNT;
               end
            end
            PHASE_BODY: begin
               sum_in = sum_ff + rx_byte;
               // id byte opens a record, data bytes land most significant first
               if (slot_ff == '0) begin
                  id_in = rx_byte;
               end else if (id_ok) begin
                  case (slot_ff)
                     SlotWidth'(1): stage_in[word_idx][31:24] = rx_byte;
                     SlotWidth'(2): stage_in[word_idx][23:16] = rx_byte;
                     SlotWidth'(3): stage_in[word_idx][15:8]  = rx_byte;
                     SlotWidth'(4): stage_in[word_idx][7:0]   = rx_byte;
                     default: ;
                  endcase
               end
               slot_in = (slot_ff == SlotWidth'(RecordLen - 1)) ? '0 : slot_ff + 1'b1;
               pos_in  = pos_ff + 1'b1;
               if (pos_ff == PosWidth'(BodyLen - 1)) begin
                  phase_in = PHASE_CHECK;
               end
            end
            PHASE_CHECK: begin
               phase_in = PHASE_HUNT;
               pos_in   = '0;
               emit     = (rx_byte == sum_ff);
            end
            default: phase_in = PHASE_HUNT;
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_HUNT;
         pos_ff   <= '0;
         slot_ff  <= '0;
         sum_ff   <= '0;
         id_ff    <= '0;
         stage_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         slot_ff  <= slot_in;
         sum_ff   <= sum_in;
         id_ff    <= id_in;
         stage_ff <= stage_in;
      end
   end

   assign frame.emit      = emit;
   assign frame.words     = stage_ff;
   assign status.hunting  = (phase_ff == PHASE_HUNT);
   assign status.checking = (phase_ff == PHASE_CHECK);

endmodule

// ===== rtl/sfd_out_reg.sv =====
// result register holding one finished frame until the receiver takes it
// depends on sfd_pkg
module sfd_out_reg import sfd_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  sfd_frame_type frame,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output sfd_words_type rsp_words,
   output logic          req_ready
);

   logic          valid_ff, valid_in;
   sfd_words_type words_ff, words_in;

   // free when empty or being drained this cycle
   assign req_ready = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      words_in = words_ff;
      if (frame.emit) begin
         valid_in = 1'b1;
         words_in = frame.words;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   // valid needs reset, payload does not
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      words_ff <= words_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_words = words_ff;

endmodule

// ===== rtl/sensor_frame_deframer_core.sv =====
// Sensor frame deframer, top level.
// Channels: req_if carries one received byte per request (rx_byte); rsp_if carries
// one decoded frame as five 32-bit words (ids 0 to 4). Both use valid/ready and
// move a request or result at a clock edge where valid and ready are both high.
// Configuration: csr_we, csr_index and csr_wdata write the header byte (index 0)
// and the start byte (index 1); other indexes are ignored. Write only when idle.
// Frame format: header, start byte, five records of id plus four data bytes
// (big endian), then an 8-bit sum of all bytes before it.
// Throughput: one byte per cycle unless an untaken result stalls requests; the
// parser updates its state in the cycle a byte is accepted.
// Result: a good checksum byte shows up as a result in the cycle after it is
// accepted. A bad checksum gives no result.
// Stall: the result register holds a frame until taken; bytes keep flowing
// as long as the register is empty or drained in the same cycle.
// Reset (synchronous, active high): registers return to 0xFF and 0x02, the
// parser hunts for a header, staging words clear to zero, no result pending.
module sensor_frame_deframer_core import sfd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   sfd_req_if.sink                  req_if,
   sfd_rsp_if.source                rsp_if,
   input  logic                     csr_we,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [ByteWidth-1:0]     csr_wdata
);

`include "sensor_frame_deframer_core_macros.svh"

   logic [ByteWidth-1:0] header_ff;
   logic [ByteWidth-1:0] start_ff;
   logic                 req_accept;
   logic                 req_ready;
   sfd_frame_type        frame;
   sfd_status_type       status;
   sfd_words_type        rsp_words;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= HeaderResetValue;
         start_ff  <= StartResetValue;
      end else if (csr_we) begin
         unique case (csr_index)
            CsrHeaderIdx: header_ff <= csr_wdata;
            CsrStartIdx:  start_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_if.ready = req_ready;
   assign req_accept   = req_if.valid && req_ready;

   sfd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .rx_byte     (req_if.rx_byte),
      .header_byte (header_ff),
      .start_byte  (start_ff),
      .frame       (frame),
      .status      (status)
   );

   sfd_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .frame     (frame),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_words (rsp_words),
      .req_ready (req_ready)
   );

   assign rsp_if.word_zero  = rsp_words[0];
   assign rsp_if.word_one   = rsp_words[1];
   assign rsp_if.word_two   = rsp_words[2];
   assign rsp_if.word_three = rsp_words[3];
   assign rsp_if.word_four  = rsp_words[4];

   // a pending result that is not taken blocks new requests
   `SFD_ASSERT_IMPL(a_no_overwrite, clock, reset, rsp_if.valid && !rsp_if.ready, !req_ready)
   // a new result follows an accepted request
   `SFD_ASSERT_IMPL(a_rsp_from_req, clock, reset, $rose(rsp_if.valid), $past(req_accept))
   // only the checksum byte can raise a result
   `SFD_ASSERT_NEXT(a_emit_on_check, clock, reset, req_accept && !status.checking && !rsp_if.valid, !rsp_if.valid)
   // no result can be emitted while hunting
   `SFD_ASSERT_IMPL(a_hunt_quiet, clock, reset, status.hunting, !frame.emit)

endmodule
